// File: rtl/escr_pkg.sv
// Package for the enhanced second-chance page replacer.
// Shared constants and the lookup/victim flag struct; no dependencies.
`default_nettype none

package escr_pkg;

    localparam int FRAMES_DEF    = 8;
    localparam int PAGE_BITS_DEF = 8;

    localparam int CFG_W         = 4;
    localparam int FRAME_INDEX_W = 3;
    localparam int FAULT_W       = 16;

    localparam logic [CFG_W-1:0]   CFG_FRAMES_RESET = 4'd8;
    localparam logic [FAULT_W-1:0] FAULT_MAX        = 16'hFFFF;

    typedef struct packed {
        logic hit;
        logic evict;
        logic clear_refs;
    } pick_flags_t;

endpackage

`default_nettype wire

// File: rtl/escr_pick.sv
// Lookup and victim selection for the second-chance replacer.
// Pure combinational; uses escr_pkg for the flag struct.
`default_nettype none

module escr_pick #(
    parameter int FRAMES    = escr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = escr_pkg::PAGE_BITS_DEF,
    parameter int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
    input  logic [escr_pkg::CFG_W-1:0] frames_cfg,
    input  logic [PAGE_BITS-1:0]       page,
    input  logic [PAGE_BITS-1:0]       frame_page [FRAMES],
    input  logic [FRAMES-1:0]          frame_valid,
    input  logic [FRAMES-1:0]          ref_bits,
    input  logic [FRAMES-1:0]          mod_bits,
    output logic [FRAMES-1:0]          active,
    output escr_pkg::pick_flags_t      flags,
    output logic [IDX_W-1:0]           idx
);

    logic [FRAMES-1:0] match;
    logic [FRAMES-1:0] empty;
    logic [FRAMES-1:0] cls00;
    logic [FRAMES-1:0] cls01;
    logic [FRAMES-1:0] clean;

    function automatic logic [IDX_W-1:0] first_set(input logic [FRAMES-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = IDX_W'(i);
            end
        end
        return r;
    endfunction

    always_comb
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            // frame 0 always takes part, count above FRAMES saturates naturally
            active[i] = (i == 0) || (i < int'(frames_cfg));
            match[i]  = active[i] && frame_valid[i] && (frame_page[i] == page);
            empty[i]  = active[i] && !frame_valid[i];
            cls00[i]  = active[i] && !ref_bits[i] && !mod_bits[i];
            cls01[i]  = active[i] && !ref_bits[i] && mod_bits[i];
            clean[i]  = active[i] && !mod_bits[i];
        end
    end

    always_comb
    begin
        flags = '0;
        idx   = '0;
        if (|match)
        begin
            flags.hit = 1'b1;
            idx       = first_set(match);
        end
        else if (|empty)
        begin
            idx = first_set(empty);
        end
        else if (|cls00)
        begin
            flags.evict = 1'b1;
            idx         = first_set(cls00);
        end
        else if (|cls01)
        begin
            flags.evict      = 1'b1;
            flags.clear_refs = 1'b1;
            idx              = first_set(cls01);
        end
        else
        begin
            // all active refs set: clear them, then first clean frame, else frame 0
            flags.evict      = 1'b1;
            flags.clear_refs = 1'b1;
            idx              = first_set(clean);
        end
    end

endmodule

`default_nettype wire

// File: rtl/enhanced_second_chance_replacer_core.sv
// Top level of the enhanced second-chance page replacer.
// Depends on escr_pkg and escr_pick.
//
//   channel   dir   handshake                  payload
//   cfg       in    cfg_wr_en                  cfg_wr_data = frames_in_use
//   s_axis    in    s_axis_tvalid/tready       page, write_access
//   m_axis    out   m_axis_tvalid/tready       hit, frame_index, evicted_valid,
//                                              evicted_page, fault_total
//
// One access per cycle unless the result stalls.
// The input register feeds a parallel compare and priority encoders; frame
// state updates as the item moves into the result register.
// Reset empties all frames, clears the fault count and sets frames_in_use to 8.
// A stalled result holds the input register; the input side stalls only then.
`default_nettype none

module enhanced_second_chance_replacer_core #(
    parameter int FRAMES    = escr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = escr_pkg::PAGE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [escr_pkg::CFG_W-1:0]            cfg_wr_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // page, write_access
    input  logic [((PAGE_BITS + 8) / 8) * 8 - 1:0]  s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // hit, frame_index, evicted_valid, evicted_page, fault_total
    output logic [((PAGE_BITS + 28) / 8) * 8 - 1:0] m_axis_tdata
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int M_W   = ((PAGE_BITS + 28) / 8) * 8;
    localparam int FIW   = escr_pkg::FRAME_INDEX_W;
    localparam int FW    = escr_pkg::FAULT_W;

    logic [escr_pkg::CFG_W-1:0] cfg_frames_reg;

    logic                 in_valid_reg, in_valid_next;
    logic [PAGE_BITS-1:0] in_page_reg;
    logic                 in_write_reg;

    logic [PAGE_BITS-1:0] frame_page_reg [FRAMES];
    logic [FRAMES-1:0]    valid_reg, valid_next;
    logic [FRAMES-1:0]    ref_reg, ref_next;
    logic [FRAMES-1:0]    mod_reg, mod_next;
    logic [FW-1:0]        fault_reg, fault_next;

    logic                 out_valid_reg, out_valid_next;
    logic [M_W-1:0]       out_data_reg, out_data_next;

    logic                  s_xfer;
    logic                  advance;
    logic [FRAMES-1:0]     active;
    escr_pkg::pick_flags_t flags;
    logic [IDX_W-1:0]      idx;
    logic [IDX_W+FIW-1:0]  idx_wide;
    logic [PAGE_BITS-1:0]  ev_page;

    escr_pick #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .IDX_W     (IDX_W)
    ) u_pick (
        .frames_cfg  (cfg_frames_reg),
        .page        (in_page_reg),
        .frame_page  (frame_page_reg),
        .frame_valid (valid_reg),
        .ref_bits    (ref_reg),
        .mod_bits    (mod_reg),
        .active      (active),
        .flags       (flags),
        .idx         (idx)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign in_valid_next  = s_xfer || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_axis_tready);

    always_comb
    begin
        valid_next = valid_reg;
        ref_next   = ref_reg;
        mod_next   = mod_reg;
        fault_next = fault_reg;
        if (advance)
        begin
            if (flags.clear_refs)
            begin
                ref_next = ref_reg & ~active;
            end
            ref_next[idx] = 1'b1;
            mod_next[idx] = in_write_reg;
            if (!flags.hit)
            begin
                valid_next[idx] = 1'b1;
                if (fault_reg != escr_pkg::FAULT_MAX)
                begin
                    fault_next = fault_reg + FW'(1);
                end
            end
        end
    end

    always_comb
    begin
        idx_wide      = {{FIW{1'b0}}, idx};
        ev_page       = flags.evict ? frame_page_reg[idx] : '0;
        out_data_next = '0;
        out_data_next[0]                         = flags.hit;
        out_data_next[FIW:1]                     = idx_wide[FIW-1:0];
        out_data_next[FIW+1]                     = flags.evict;
        out_data_next[PAGE_BITS+FIW+1:FIW+2]     = ev_page;
        out_data_next[PAGE_BITS+FIW+FW+1:PAGE_BITS+FIW+2] = fault_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_frames_reg <= escr_pkg::CFG_FRAMES_RESET;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            valid_reg      <= '0;
            ref_reg        <= '0;
            mod_reg        <= '0;
            fault_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cfg_frames_reg <= cfg_wr_data;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
            ref_reg       <= ref_next;
            mod_reg       <= mod_next;
            fault_reg     <= fault_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            in_page_reg  <= s_axis_tdata[PAGE_BITS-1:0];
            in_write_reg <= s_axis_tdata[PAGE_BITS];
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
            if (!flags.hit)
            begin
                frame_page_reg[idx] <= in_page_reg;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/escr_checker.sv
// Port-level checks for the enhanced second-chance replacer core.
// Depends on enhanced_second_chance_replacer_core for the bind target.
`default_nettype none

module escr_checker #(
    parameter int PAGE_BITS = escr_pkg::PAGE_BITS_DEF
) (
    input wire logic                                  clk,
    input wire logic                                  rst_n,
    input wire logic                                  s_axis_tready,
    input wire logic                                  m_axis_tvalid,
    input wire logic                                  m_axis_tready,
    input wire logic [((PAGE_BITS + 28) / 8) * 8 - 1:0] m_axis_tdata
);

    localparam int FW = escr_pkg::FAULT_W;

    logic          m_xfer;
    logic          hit_w;
    logic          ev_w;
    logic [FW-1:0] fault_w;
    logic [FW-1:0] last_fault_reg;

    assign m_xfer  = m_axis_tvalid && m_axis_tready;
    assign hit_w   = m_axis_tdata[0];
    assign ev_w    = m_axis_tdata[4];
    assign fault_w = m_axis_tdata[PAGE_BITS+20:PAGE_BITS+5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_fault_reg <= '0;
        end
        else if (m_xfer)
        begin
            last_fault_reg <= fault_w;
        end
    end

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_in_ready_when_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output side is ready");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && hit_w |-> !ev_w)
        else $error("eviction reported on a hit");

    a_hit_count_same: assert property (@(posedge clk) disable iff (!rst_n)
        m_xfer && hit_w |-> fault_w == last_fault_reg)
        else $error("fault count moved on a hit");

    a_miss_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_xfer && !hit_w |-> (fault_w == FW'(last_fault_reg + FW'(1)))
                          || (fault_w == escr_pkg::FAULT_MAX
                              && last_fault_reg == escr_pkg::FAULT_MAX))
        else $error("fault count did not step on a miss");

endmodule

bind enhanced_second_chance_replacer_core escr_checker #(
    .PAGE_BITS (PAGE_BITS)
) u_escr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
